FILE: hw/rtl/utf8d_pkg.sv
// Shared types, constants and helper functions of the UTF-8 stream decoder.
package utf8d_pkg;

    localparam int unsigned CP_W  = 21;
    localparam int unsigned CNT_W = 3;

    localparam logic [CP_W-1:0]  BAD_CP       = 21'd63;
    localparam logic [CP_W-1:0]  MIN_CP_LEN2  = 21'h00080;
    localparam logic [CP_W-1:0]  MIN_CP_LEN3  = 21'h00800;
    localparam logic [CP_W-1:0]  MIN_CP_LEN4  = 21'h10000;
    localparam logic [CP_W-1:0]  SURR_LO      = 21'h0D800;
    localparam logic [CP_W-1:0]  SURR_HI      = 21'h0DFFF;
    localparam logic [CP_W-1:0]  MAX_CP       = 21'h10FFFF;

    localparam logic [CNT_W-1:0] LEN_NONE = 3'd0;
    localparam logic [CNT_W-1:0] LEN_1    = 3'd1;
    localparam logic [CNT_W-1:0] LEN_2    = 3'd2;
    localparam logic [CNT_W-1:0] LEN_3    = 3'd3;
    localparam logic [CNT_W-1:0] LEN_4    = 3'd4;

    // Decoder state carried from word to word
    typedef struct packed {
        logic [CNT_W-1:0] exp_len;
        logic [CNT_W-1:0] rx_cnt;
        logic [CP_W-1:0]  partial;
    } t_seq_state;

    // Results released by one word: n_bad one-byte '?' results, then the main result
    typedef struct packed {
        logic [CNT_W-1:0] n_bad;
        logic             main_v;
        logic [CP_W-1:0]  main_cp;
        logic [CNT_W-1:0] main_cnt;
    } t_results;

    function automatic logic [CP_W-1:0] checked_value(input logic [CP_W-1:0]  v,
                                                      input logic [CNT_W-1:0] len);
        logic bad;
        bad = 1'b0;
        if (len == LEN_2 && v < MIN_CP_LEN2) begin
            bad = 1'b1;
        end
        if (len == LEN_3 && (v < MIN_CP_LEN3 || (v >= SURR_LO && v <= SURR_HI))) begin
            bad = 1'b1;
        end
        if (len == LEN_4 && (v < MIN_CP_LEN4 || v > MAX_CP)) begin
            bad = 1'b1;
        end
        return bad ? BAD_CP : v;
    endfunction

    function automatic logic [CNT_W-1:0] sat3(input logic [CNT_W-1:0] c);
        return (c > LEN_3) ? LEN_3 : c;
    endfunction

endpackage

FILE: hw/rtl/utf8d_decode.sv
// Combinational step of the decoder: one word against the current sequence state.
module utf8d_decode (
    input  logic [7:0]             i_byte,
    input  logic                   i_eot,
    input  utf8d_pkg::t_seq_state  i_state,
    output utf8d_pkg::t_seq_state  o_state,
    output utf8d_pkg::t_results    o_res
);
    import utf8d_pkg::*;

    logic             cont;
    logic [CNT_W-1:0] rc_inc;
    logic [CP_W-1:0]  pv_shift;
    logic [CNT_W-1:0] pre_bad;
    logic             opened;

    assign cont     = (i_byte[7:6] == 2'b10);
    assign rc_inc   = i_state.rx_cnt + LEN_1;
    assign pv_shift = {i_state.partial[CP_W-7:0], i_byte[5:0]};

    always_comb begin
        o_state = i_state;
        o_res   = '0;
        pre_bad = '0;
        opened  = 1'b0;
        if (i_state.exp_len != LEN_NONE && cont) begin
            o_state.rx_cnt  = rc_inc;
            o_state.partial = pv_shift;
            if (rc_inc >= i_state.exp_len) begin
                o_res.main_v   = 1'b1;
                o_res.main_cp  = checked_value(pv_shift, i_state.exp_len);
                o_res.main_cnt = i_state.exp_len;
                o_state        = '0;
            end else if (i_eot) begin
                o_res.n_bad = sat3(rc_inc);
                o_state     = '0;
            end
        end else begin
            // drop any open sequence, one '?' per pending byte
            if (i_state.exp_len != LEN_NONE) begin
                pre_bad = sat3(i_state.rx_cnt);
            end
            o_state = '0;
            priority if (!i_byte[7]) begin
                o_res.main_v   = 1'b1;
                o_res.main_cp  = {13'd0, i_byte};
                o_res.main_cnt = LEN_1;
            end else if (i_byte[7:5] == 3'b110) begin
                opened          = 1'b1;
                o_state.exp_len = LEN_2;
                o_state.rx_cnt  = LEN_1;
                o_state.partial = {16'd0, i_byte[4:0]};
            end else if (i_byte[7:4] == 4'b1110) begin
                opened          = 1'b1;
                o_state.exp_len = LEN_3;
                o_state.rx_cnt  = LEN_1;
                o_state.partial = {17'd0, i_byte[3:0]};
            end else if (i_byte[7:3] == 5'b11110) begin
                opened          = 1'b1;
                o_state.exp_len = LEN_4;
                o_state.rx_cnt  = LEN_1;
                o_state.partial = {18'd0, i_byte[2:0]};
            end else begin
                o_res.main_v   = 1'b1;
                o_res.main_cp  = BAD_CP;
                o_res.main_cnt = LEN_1;
            end
            o_res.n_bad = pre_bad;
            // a lead on the final word is flushed at once
            if (i_eot && opened) begin
                o_res.n_bad = pre_bad + LEN_1;
                o_state     = '0;
            end
        end
    end

endmodule

FILE: hw/rtl/utf8_stream_decoder_unit.sv
// Top level of the UTF-8 stream decoder: input register, decode step, result buffer.
// A word is taken into an input register, decoded against the open sequence in one pass
// and moved into a result buffer that releases up to four code points, one per cycle
// while i_ready is high. Words that complete a sequence or are plain ASCII run back to
// back at one per cycle unless the output stalls; a word that opens or extends a sequence
// gives no result. A broken sequence, or an open one on the final word, releases one '?'
// per pending byte before any new result, so a word can leave up to four results in the
// result buffer; the input register keeps taking one further word during that time.
module utf8_stream_decoder_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [7:0]                i_in_byte,
    input  logic                      i_end_of_text,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [utf8d_pkg::CP_W-1:0]  o_code_point,
    output logic [utf8d_pkg::CNT_W-1:0] o_byte_count,
    output logic                      o_run_last
);
    import utf8d_pkg::*;

    logic             r_in_v;
    logic [7:0]       r_in_byte;
    logic             r_in_eot;
    t_seq_state       r_state;
    t_seq_state       n_state;
    t_results         dec_res;
    logic [CNT_W-1:0] r_n_bad;
    logic             r_main_v;
    logic [CP_W-1:0]  r_main_cp;
    logic [CNT_W-1:0] r_main_cnt;
    logic             buf_empty;
    logic             buf_last;
    logic             out_fire;
    logic             xfer;

    utf8d_decode u_decode (
        .i_byte  (r_in_byte),
        .i_eot   (r_in_eot),
        .i_state (r_state),
        .o_state (n_state),
        .o_res   (dec_res)
    );

    assign buf_empty = (r_n_bad == LEN_NONE) && !r_main_v;
    assign buf_last  = (r_n_bad == LEN_1 && !r_main_v) || (r_n_bad == LEN_NONE && r_main_v);
    assign out_fire  = o_valid && i_ready;
    // advance the held word once the buffer drains this cycle
    assign xfer      = r_in_v && (buf_empty || (out_fire && buf_last));
    assign o_ready   = !r_in_v || xfer;

    assign o_valid      = !buf_empty;
    assign o_code_point = (r_n_bad != LEN_NONE) ? BAD_CP : r_main_cp;
    assign o_byte_count = (r_n_bad != LEN_NONE) ? LEN_1 : r_main_cnt;
    assign o_run_last   = buf_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_v <= 1'b1;
        end else if (xfer) begin
            r_in_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_in_byte;
            r_in_eot  <= i_end_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= '0;
            r_n_bad  <= '0;
            r_main_v <= 1'b0;
        end else if (xfer) begin
            r_state  <= n_state;
            r_n_bad  <= dec_res.n_bad;
            r_main_v <= dec_res.main_v;
        end else if (out_fire) begin
            if (r_n_bad != LEN_NONE) begin
                r_n_bad <= r_n_bad - LEN_1;
            end else begin
                r_main_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (xfer) begin
            r_main_cp  <= dec_res.main_cp;
            r_main_cnt <= dec_res.main_cnt;
        end
    end

endmodule

FILE: hw/rtl/utf8d_checker.sv
// Port-level checks on the result channel of the decoder, bound to the top level.
module utf8d_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [utf8d_pkg::CP_W-1:0]  o_code_point,
    input logic [utf8d_pkg::CNT_W-1:0] o_byte_count,
    input logic                        o_run_last
);
    import utf8d_pkg::*;

    // only the final result of a word may carry a real code point or a multi-byte count
    a_non_last_is_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_run_last) |-> (o_code_point == BAD_CP && o_byte_count == LEN_1))
        else $error("non-final result is not a one-byte '?'");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_byte_count >= LEN_1 && o_byte_count <= LEN_4))
        else $error("byte count out of range");

    a_cp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_code_point <= MAX_CP))
        else $error("code point above the Unicode range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_code_point)
                                   && $stable(o_byte_count) && $stable(o_run_last)))
        else $error("stalled result changed");

endmodule

bind utf8_stream_decoder_unit utf8d_checker u_utf8d_checker (.*);
